// ----- hw/rtl/itcrd_pkg.sv -----
package itcrd_pkg;

   // sizing
   localparam int MAX_BASE     = 16;
   localparam int ALPHABET_CAP = 16;
   localparam int DIGIT_SLOTS  = 32;
   localparam int DIGIT_W      = 4;
   localparam int SLOT_AW      = $clog2(DIGIT_SLOTS);
   localparam int COUNT_W      = SLOT_AW + 1;
   localparam int VALUE_W      = 32;
   localparam int CHAR_W       = 8;
   localparam int RADIX_W      = 5;
   localparam int CSR_DATA_W   = 64;
   localparam int CSR_INDEX_W  = 2;

   // special characters
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA_LOW  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA_HIGH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RADIX      = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE,
      ST_SIGN,
      ST_EMIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic div_step;
      logic sign_push;
      logic digit_push;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic alpha_ok;
      logic digit_done;
      logic more_digits;
      logic negative;
      logic slot_free;
      logic ptr_zero;
   } dp_status_type;

endpackage

// ----- hw/rtl/itcrd_if.sv -----
interface itcrd_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [itcrd_pkg::VALUE_W-1:0]  value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface itcrd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [itcrd_pkg::CHAR_W-1:0]  character;
   logic                          last;

   modport source (output valid, output character, output last, input ready);
   modport sink   (input valid, input character, input last, output ready);
endinterface

interface itcrd_csr_if;
   logic                               valid;
   logic                               ready;
   logic [itcrd_pkg::CSR_INDEX_W-1:0]  index;
   logic [itcrd_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/itcrd_ram.sv -----
module itcrd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- hw/rtl/itcrd_ctrl.sv -----
module itcrd_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  itcrd_pkg::dp_status_type status,
   output itcrd_pkg::dp_cmd_type    cmd
);

   itcrd_pkg::state_type state_ff;
   itcrd_pkg::state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= itcrd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         itcrd_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = itcrd_pkg::ST_CHECK;
            end
         end
         itcrd_pkg::ST_CHECK: begin
            state_in = status.alpha_ok ? itcrd_pkg::ST_DIVIDE : itcrd_pkg::ST_IDLE;
         end
         itcrd_pkg::ST_DIVIDE: begin
            if (status.digit_done && !status.more_digits) begin
               state_in = itcrd_pkg::ST_SIGN;
            end
         end
         itcrd_pkg::ST_SIGN: begin
            if (!status.negative || status.slot_free) begin
               state_in = itcrd_pkg::ST_EMIT;
            end
         end
         itcrd_pkg::ST_EMIT: begin
            if (status.slot_free && status.ptr_zero) begin
               state_in = itcrd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = itcrd_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready      = 1'b0;
      cmd.load       = 1'b0;
      cmd.div_step   = 1'b0;
      cmd.sign_push  = 1'b0;
      cmd.digit_push = 1'b0;
      case (state_ff)
         itcrd_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         itcrd_pkg::ST_CHECK: begin
         end
         itcrd_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         itcrd_pkg::ST_SIGN: begin
            cmd.sign_push = status.negative && status.slot_free;
         end
         itcrd_pkg::ST_EMIT: begin
            cmd.digit_push = status.slot_free;
         end
         default: begin
         end
      endcase
   end

endmodule

// ----- hw/rtl/itcrd_dp.sv -----
module itcrd_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic signed [itcrd_pkg::VALUE_W-1:0] req_value,
   itcrd_rsp_if.source                          rsp_ch,
   itcrd_csr_if.sink                            csr_ch,
   input  itcrd_pkg::dp_cmd_type                cmd,
   output itcrd_pkg::dp_status_type             status
);

   // configuration registers
   logic [itcrd_pkg::CSR_DATA_W-1:0] alpha_lo_ff;
   logic [itcrd_pkg::CSR_DATA_W-1:0] alpha_hi_ff;
   logic [itcrd_pkg::RADIX_W-1:0]    radix_ff;

   // division state
   logic [itcrd_pkg::VALUE_W-1:0]    mag_ff;
   logic [itcrd_pkg::VALUE_W-1:0]    mag_in;
   logic                             neg_ff;
   logic                             neg_in;
   logic [1:0]                       byte_ff;
   logic [1:0]                       byte_in;
   logic [itcrd_pkg::RADIX_W-1:0]    rem_ff;
   logic [itcrd_pkg::RADIX_W-1:0]    rem_in;
   logic [itcrd_pkg::COUNT_W-1:0]    count_ff;
   logic [itcrd_pkg::COUNT_W-1:0]    count_in;
   logic [itcrd_pkg::SLOT_AW-1:0]    ptr_ff;
   logic [itcrd_pkg::SLOT_AW-1:0]    ptr_in;

   // output register
   logic                             out_valid_ff;
   logic                             out_valid_in;
   logic [itcrd_pkg::CHAR_W-1:0]     out_char_ff;
   logic [itcrd_pkg::CHAR_W-1:0]     out_char_in;
   logic                             out_last_ff;
   logic                             out_last_in;

   logic [itcrd_pkg::VALUE_W-1:0]    raw;
   logic [itcrd_pkg::VALUE_W-1:0]    mag_load;
   logic [itcrd_pkg::CHAR_W-1:0]     sel_byte;
   logic [itcrd_pkg::CHAR_W-1:0]     qbyte;
   logic [itcrd_pkg::RADIX_W-1:0]    rem_next;
   logic [itcrd_pkg::VALUE_W-1:0]    mag_step;
   logic                             digit_done;
   logic                             ram_wr_en;
   logic [itcrd_pkg::DIGIT_W-1:0]    ram_rd_data;
   logic                             slot_free;
   logic                             alpha_ok;

   function automatic logic [1:0] top_byte(input logic [itcrd_pkg::VALUE_W-1:0] m);
      logic [1:0] b;
      if (m[31:24] != 8'd0) begin
         b = 2'd3;
      end else if (m[23:16] != 8'd0) begin
         b = 2'd2;
      end else if (m[15:8] != 8'd0) begin
         b = 2'd1;
      end else begin
         b = 2'd0;
      end
      return b;
   endfunction

   function automatic logic [itcrd_pkg::CHAR_W-1:0] alpha_char(
      input logic [itcrd_pkg::CSR_DATA_W-1:0] lo,
      input logic [itcrd_pkg::CSR_DATA_W-1:0] hi,
      input logic [itcrd_pkg::DIGIT_W-1:0]    k
   );
      logic [itcrd_pkg::CSR_DATA_W-1:0] word;
      word = k[3] ? hi : lo;
      return word[{k[2:0], 3'b000} +: 8];
   endfunction

   // configuration writes
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_lo_ff <= '0;
         alpha_hi_ff <= '0;
         radix_ff    <= '0;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            itcrd_pkg::CSR_ALPHA_LOW:  alpha_lo_ff <= csr_ch.data;
            itcrd_pkg::CSR_ALPHA_HIGH: alpha_hi_ff <= csr_ch.data;
            itcrd_pkg::CSR_RADIX:      radix_ff    <= csr_ch.data[itcrd_pkg::RADIX_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // alphabet check: radix range, forbidden characters, repeats
   always_comb begin
      logic [itcrd_pkg::CHAR_W-1:0] ci;
      alpha_ok = ({1'b0, radix_ff} >= 6'd2)
              && ({1'b0, radix_ff} <= 6'(itcrd_pkg::MAX_BASE))
              && ({1'b0, radix_ff} <= 6'(itcrd_pkg::ALPHABET_CAP));
      for (int i = 0; i < itcrd_pkg::ALPHABET_CAP; i++) begin
         ci = alpha_char(alpha_lo_ff, alpha_hi_ff, 4'(i));
         if (5'(i) < radix_ff) begin
            if (ci == 8'd0 || ci == itcrd_pkg::CHAR_PLUS || ci == itcrd_pkg::CHAR_MINUS) begin
               alpha_ok = 1'b0;
            end
            for (int j = 0; j < i; j++) begin
               if (alpha_char(alpha_lo_ff, alpha_hi_ff, 4'(j)) == ci) begin
                  alpha_ok = 1'b0;
               end
            end
         end
      end
   end

   // magnitude of the incoming value, wraps correctly for the most negative one
   assign raw      = $unsigned(req_value);
   assign mag_load = raw[31] ? (32'd0 - raw) : raw;

   // eight restoring division steps on one byte of the magnitude
   always_comb begin
      logic [itcrd_pkg::RADIX_W-1:0] rv;
      logic [itcrd_pkg::RADIX_W-1:0] trial;
      sel_byte = mag_ff[{byte_ff, 3'b000} +: 8];
      rv       = rem_ff;
      qbyte    = '0;
      for (int i = 7; i >= 0; i--) begin
         trial = {rv[3:0], sel_byte[i]};
         if (trial >= radix_ff) begin
            qbyte[i] = 1'b1;
            rv       = trial - radix_ff;
         end else begin
            rv = trial;
         end
      end
      rem_next = rv;
      mag_step = mag_ff;
      mag_step[{byte_ff, 3'b000} +: 8] = qbyte;
   end

   assign digit_done = (byte_ff == 2'd0);
   assign ram_wr_en  = cmd.div_step && digit_done;
   assign slot_free  = !out_valid_ff || rsp_ch.ready;

   // next values of the division and readout state
   always_comb begin
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      byte_in  = byte_ff;
      rem_in   = rem_ff;
      count_in = count_ff;
      ptr_in   = ptr_ff;
      if (cmd.load) begin
         mag_in   = mag_load;
         neg_in   = raw[31];
         byte_in  = top_byte(mag_load);
         rem_in   = '0;
         count_in = '0;
      end else if (cmd.div_step) begin
         mag_in = mag_step;
         if (digit_done) begin
            count_in = count_ff + 1'b1;
            rem_in   = '0;
            byte_in  = top_byte(mag_step);
            ptr_in   = count_ff[itcrd_pkg::SLOT_AW-1:0];
         end else begin
            byte_in = byte_ff - 1'b1;
            rem_in  = rem_next;
         end
      end else if (cmd.digit_push) begin
         ptr_in = ptr_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      byte_ff  <= byte_in;
      rem_ff   <= rem_in;
      count_ff <= count_in;
      ptr_ff   <= ptr_in;
   end

   // digit buffer, read address follows the next pointer
   itcrd_ram #(
      .WIDTH (itcrd_pkg::DIGIT_W),
      .DEPTH (itcrd_pkg::DIGIT_SLOTS)
   ) u_digit_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[itcrd_pkg::SLOT_AW-1:0]),
      .wr_data (rem_next[itcrd_pkg::DIGIT_W-1:0]),
      .rd_addr (ptr_in),
      .rd_data (ram_rd_data)
   );

   // output register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      if (cmd.sign_push) begin
         out_valid_in = 1'b1;
         out_char_in  = itcrd_pkg::CHAR_MINUS;
         out_last_in  = 1'b0;
      end else if (cmd.digit_push) begin
         out_valid_in = 1'b1;
         out_char_in  = alpha_char(alpha_lo_ff, alpha_hi_ff, ram_rd_data);
         out_last_in  = (ptr_ff == '0);
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.character = out_char_ff;
   assign rsp_ch.last      = out_last_ff;

   // status to the controller
   assign status.alpha_ok    = alpha_ok;
   assign status.digit_done  = digit_done;
   assign status.more_digits = (mag_step != '0)
                            && (count_ff != itcrd_pkg::COUNT_W'(itcrd_pkg::DIGIT_SLOTS - 1));
   assign status.negative    = neg_ff;
   assign status.slot_free   = slot_free;
   assign status.ptr_zero    = (ptr_ff == '0);

endmodule

// ----- hw/rtl/integer_to_custom_radix_digits.sv -----
// sequence: accept, a check state, per digit one byte-wide restoring divider step for each
//   byte from the highest nonzero byte of the magnitude down, a sign state, then one digit
//   per output beat while the output register is free; the sign, if any, is sent first
// throughput: one value at a time; the longest result is 33 characters (radix 2, -2^31)
// reset: synchronous, clears control state and the alphabet and radix registers;
//   the digit buffer is not cleared and needs no clearing pass
module integer_to_custom_radix_digits (
   input  logic        clock,
   input  logic        reset,
   itcrd_req_if.sink   req_ch,
   itcrd_rsp_if.source rsp_ch,
   itcrd_csr_if.sink   csr_ch
);

   itcrd_pkg::dp_cmd_type    cmd;
   itcrd_pkg::dp_status_type status;
   logic                     req_ready;

   assign req_ch.ready = req_ready;

   // sequencer
   itcrd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // divider, digit buffer, output register, configuration
   itcrd_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_value (req_ch.value),
      .rsp_ch    (rsp_ch),
      .csr_ch    (csr_ch),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

// ----- hw/rtl/itcrd_checker.sv -----
module itcrd_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [itcrd_pkg::CHAR_W-1:0]       rsp_character,
   input logic                               rsp_last
);

   // a stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_character) && $stable(rsp_last))
      else $error("rsp beat changed while stalled");

   // nothing comes out right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // the sign is never the final character
   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_character == itcrd_pkg::CHAR_MINUS |-> !rsp_last)
      else $error("sign beat flagged last");

   // one value at a time: no new beat right after an accepted one
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req ready right after accept");

endmodule

bind integer_to_custom_radix_digits itcrd_checker u_itcrd_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_character (rsp_ch.character),
   .rsp_last      (rsp_ch.last)
);
